// ===== rtl/core/mtic_pkg.sv =====
// Shared types and constants for the map tile ID codec.
package mtic_pkg;

  // Operation codes carried on the opcode input.
  typedef enum logic [2:0] {
    OP_ENCODE      = 3'd0,
    OP_LOWER_LEFT  = 3'd1,
    OP_CENTER      = 3'd2,
    OP_UPPER_RIGHT = 3'd3,
    OP_NORMALIZE   = 3'd4
  } mtic_op_t;

  // Largest divisor exponent used by normalization.
  localparam logic [3:0]  SHIFT_MAX  = 4'd12;
  // Latitude offset applied before interleaving.
  localparam logic [31:0] LAT_OFFSET = 32'h4000_0000;
  // Magnitude limit of a normalized offset.
  localparam logic [12:0] NORM_LIMIT = 13'd4096;

  // Load enables of the two normalization stages.
  typedef struct packed {
    logic s4;
    logic s5;
  } mtic_adv_t;

endpackage

// ===== rtl/core/mtic_norm.sv =====
// Two-stage normalizer: rounded power-of-two division of a signed offset with clamping.
module mtic_norm (
  input  logic                    clk,
  input  mtic_pkg::mtic_adv_t     adv,
  input  logic [31:0]             diff,
  input  logic [3:0]              shift,
  output logic signed [13:0]      result
);
  import mtic_pkg::*;

  logic        neg_c;
  logic [32:0] rnd_c;
  logic [32:0] sum_c;
  logic [32:0] sum4;
  logic        neg4;
  logic [3:0]  sh4;
  logic [32:0] quo_c;
  logic [12:0] mag_c;
  logic [13:0] res_c;

  // Magnitude plus the rounding half-unit, done as one add with a carry-in.
  always_comb begin
    neg_c = diff[31];
    rnd_c = (shift == 4'd0) ? 33'd0 : (33'd1 << (shift - 4'd1));
    sum_c = {1'b0, (neg_c ? ~diff : diff)} + {32'd0, neg_c} + rnd_c;
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      sum4 <= sum_c;
      neg4 <= neg_c;
      sh4  <= shift;
    end
  end

  // Shift down, clamp to the limit and restore the sign.
  always_comb begin
    quo_c = sum4 >> sh4;
    mag_c = (quo_c > {20'd0, NORM_LIMIT}) ? NORM_LIMIT : quo_c[12:0];
    res_c = neg4 ? (14'd0 - {1'b0, mag_c}) : {1'b0, mag_c};
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      result <= res_c;
    end
  end

endmodule

// ===== rtl/core/map_tile_id_codec.sv =====
// Map tile ID codec: five-stage pipeline for tile ID encode, decode and normalization.
//
// Requests enter on the input channel (in_valid / in_stall) with opcode, level,
// longitude, latitude, packed_id and coord_shift; each request gives exactly one
// result on the output channel (out_valid / out_stall), in request order.
// A request passes through stages 1 to 5 in order, and out_valid is the stage 5
// valid bit. Throughput is one request per cycle while out_stall is low; the five
// register stages each hold one request and every stage loads whenever it is
// empty or the stage after it moves.
// When the receiver raises out_stall the result register holds its contents;
// requests keep entering until the empty stages are filled, then in_stall rises.
// in_stall depends on out_stall combinationally through the stage chain.
// Reset clears every stage valid bit; the block can take a request as soon as
// reset is released.
// Stage 1 finds the level and de-interleaves the ID, stage 2 shifts out the
// corner or builds the packed ID, stage 3 forms the offset from the centre, and
// stages 4 and 5 round, shift and clamp the normalized offsets.
module map_tile_id_codec (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic [3:0]         level,
  input  logic signed [31:0] longitude,
  input  logic signed [31:0] latitude,
  input  logic [31:0]        packed_id,
  input  logic [3:0]         coord_shift,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [31:0]        packed_id_out,
  output logic [3:0]         level_out,
  output logic signed [31:0] longitude_out,
  output logic signed [31:0] latitude_out,
  output logic signed [13:0] norm_x,
  output logic signed [13:0] norm_y
);
  import mtic_pkg::*;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  mtic_adv_t adv;

  // Each stage loads when empty or when its successor moves.
  assign rdy5     = !v5 || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;
  assign adv.s4   = rdy4;
  assign adv.s5   = rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Stage 1: level search, marker removal and de-interleaving of the ID.
  logic [15:0] hi_c;
  logic [3:0]  dlvl_c;
  logic [15:0] onehot_c;
  logic [31:0] tile_c;
  logic [15:0] xb_c, yb_c;
  logic        fail_c;
  logic [3:0]  sh_c;
  logic [31:0] latp_c;

  always_comb begin
    hi_c   = packed_id[31:16];
    dlvl_c = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (hi_c[k]) dlvl_c = 4'(k);
    end
    onehot_c = 16'd1 << dlvl_c;
    tile_c   = {hi_c & ~onehot_c, packed_id[15:0]};
    for (int k = 0; k < 16; k++) begin
      xb_c[k] = tile_c[2*k]   & (4'(k) <= dlvl_c);
      yb_c[k] = tile_c[2*k+1] & (4'(k) <= dlvl_c);
    end
    // The top latitude bit is stored inverted.
    yb_c   = yb_c ^ (onehot_c >> 1);
    fail_c = (opcode == OP_ENCODE) ? 1'b0 : ((opcode > OP_NORMALIZE) || (hi_c == 16'd0));
    sh_c   = (coord_shift > SHIFT_MAX) ? SHIFT_MAX : coord_shift;
    latp_c = $unsigned(latitude) + LAT_OFFSET;
  end

  logic [2:0]  s1_op;
  logic [3:0]  s1_lvl_in;
  logic [31:0] s1_lon, s1_lat, s1_latp;
  logic        s1_fail;
  logic [3:0]  s1_dlvl;
  logic [15:0] s1_xb, s1_yb;
  logic [3:0]  s1_sh;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_op     <= opcode;
      s1_lvl_in <= level;
      s1_lon    <= longitude;
      s1_lat    <= latitude;
      s1_latp   <= latp_c;
      s1_fail   <= fail_c;
      s1_dlvl   <= dlvl_c;
      s1_xb     <= xb_c;
      s1_yb     <= yb_c;
      s1_sh     <= sh_c;
    end
  end

  // Stage 2: build the packed ID, or shift the corner into place and offset it.
  logic [4:0]  esh_c;
  logic [31:0] xs_c, ys_c;
  logic [15:0] ymask_c, x16_c, y16_c;
  logic [31:0] enc_c, pid_c;
  logic [4:0]  dsh_c;
  logic [31:0] cxr_c, cyr_c, off_c;
  logic [31:0] cx_c, cy_c;

  always_comb begin
    esh_c   = 5'd31 - {1'b0, s1_lvl_in};
    xs_c    = {1'b0, s1_lon[30:0]} >> esh_c;
    ys_c    = s1_latp >> esh_c;
    ymask_c = (16'd1 << s1_lvl_in) - 16'd1;
    x16_c   = xs_c[15:0];
    y16_c   = (ys_c[15:0] & ymask_c) ^ (ymask_c ^ (ymask_c >> 1));
    for (int k = 0; k < 16; k++) begin
      enc_c[2*k]   = x16_c[k];
      enc_c[2*k+1] = y16_c[k];
    end
    pid_c = enc_c | (32'd1 << (5'd16 + {1'b0, s1_lvl_in}));

    dsh_c = 5'd31 - {1'b0, s1_dlvl};
    cxr_c = {16'd0, s1_xb} << dsh_c;
    cyr_c = {16'd0, s1_yb} << dsh_c;
    priority if (s1_op == OP_CENTER || s1_op == OP_NORMALIZE) begin
      off_c = 32'd1 << (5'd30 - {1'b0, s1_dlvl});
    end else if (s1_op == OP_UPPER_RIGHT) begin
      off_c = 32'd1 << dsh_c;
    end else begin
      off_c = 32'd0;
    end
    cx_c = cxr_c + off_c;
    cy_c = cyr_c - LAT_OFFSET + off_c;
  end

  logic [2:0]  s2_op;
  logic        s2_fail;
  logic [3:0]  s2_lvl;
  logic [31:0] s2_pid, s2_cx, s2_cy, s2_lon, s2_lat;
  logic [3:0]  s2_sh;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_op   <= s1_op;
      s2_fail <= s1_fail;
      s2_lon  <= s1_lon;
      s2_lat  <= s1_lat;
      s2_sh   <= s1_sh;
      priority if (s1_fail) begin
        s2_lvl <= 4'd0;
        s2_pid <= 32'd0;
        s2_cx  <= 32'd0;
        s2_cy  <= 32'd0;
      end else if (s1_op == OP_ENCODE) begin
        s2_lvl <= s1_lvl_in;
        s2_pid <= pid_c;
        s2_cx  <= 32'd0;
        s2_cy  <= 32'd0;
      end else begin
        s2_lvl <= s1_dlvl;
        s2_pid <= 32'd0;
        s2_cx  <= cx_c;
        s2_cy  <= cy_c;
      end
    end
  end

  // Stage 3: offset of the coordinate from the tile centre, zero when unused.
  logic        norm_en_c;
  logic        s3_fail;
  logic [3:0]  s3_lvl;
  logic [31:0] s3_pid, s3_cx, s3_cy, s3_dx, s3_dy;
  logic [3:0]  s3_sh;

  assign norm_en_c = (s2_op == OP_NORMALIZE) && !s2_fail;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_fail <= s2_fail;
      s3_lvl  <= s2_lvl;
      s3_pid  <= s2_pid;
      s3_cx   <= s2_cx;
      s3_cy   <= s2_cy;
      s3_sh   <= s2_sh;
      s3_dx   <= norm_en_c ? (s2_lon - s2_cx) : 32'd0;
      s3_dy   <= norm_en_c ? (s2_lat - s2_cy) : 32'd0;
    end
  end

  // Stages 4 and 5: pass-through of the decoded fields alongside the normalizers.
  logic        s4_fail;
  logic [3:0]  s4_lvl;
  logic [31:0] s4_pid, s4_cx, s4_cy;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_fail <= s3_fail;
      s4_lvl  <= s3_lvl;
      s4_pid  <= s3_pid;
      s4_cx   <= s3_cx;
      s4_cy   <= s3_cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      status        <= s4_fail;
      level_out     <= s4_lvl;
      packed_id_out <= s4_pid;
      longitude_out <= s4_cx;
      latitude_out  <= s4_cy;
    end
  end

  mtic_norm u_norm_x (
    .clk    (clk),
    .adv    (adv),
    .diff   (s3_dx),
    .shift  (s3_sh),
    .result (norm_x)
  );

  mtic_norm u_norm_y (
    .clk    (clk),
    .adv    (adv),
    .diff   (s3_dy),
    .shift  (s3_sh),
    .result (norm_y)
  );

  assign out_valid = v5;

endmodule

// ===== rtl/core/mtic_checker.sv =====
// Port-level assertions for the map tile ID codec and the bind that attaches them.
module mtic_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               status,
  input logic [31:0]        packed_id_out,
  input logic [3:0]         level_out,
  input logic signed [31:0] longitude_out,
  input logic signed [31:0] latitude_out,
  input logic signed [13:0] norm_x,
  input logic signed [13:0] norm_y
);

  // A stalled result stays valid, and its packed ID, coordinates and norm_x stay unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(packed_id_out)
      && $stable(longitude_out) && $stable(latitude_out) && $stable(norm_x))
    else $error("stalled result changed");

  // With the receiver free, every stage moves and a request is always taken.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // A failed request carries nothing but its status.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> packed_id_out == 32'd0 && level_out == 4'd0
      && longitude_out == 32'sd0 && latitude_out == 32'sd0
      && norm_x == 14'sd0 && norm_y == 14'sd0)
    else $error("failed result has nonzero fields");

  // Normalized offsets stay within the clamp.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_x >= -14'sd4096 && norm_x <= 14'sd4096
      && norm_y >= -14'sd4096 && norm_y <= 14'sd4096)
    else $error("normalized offset out of range");

  // An encoded ID has its level marker as the highest set bit.
  a_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status && packed_id_out != 32'd0
      |-> (packed_id_out >> (5'd16 + {1'b0, level_out})) == 32'd1)
    else $error("packed ID marker does not match level");

endmodule

bind map_tile_id_codec mtic_checker u_mtic_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .packed_id_out (packed_id_out),
  .level_out     (level_out),
  .longitude_out (longitude_out),
  .latitude_out  (latitude_out),
  .norm_x        (norm_x),
  .norm_y        (norm_y)
);
